@@ src/complex_halfband_decimator_top_defines.svh @@
// Assertion macros shared by the complex halfband decimator RTL.
`ifndef COMPLEX_HALFBAND_DECIMATOR_TOP_DEFINES_SVH
`define COMPLEX_HALFBAND_DECIMATOR_TOP_DEFINES_SVH

`ifndef SYNTH
// Clocked check, masked while reset is held.
`define CHBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("chbd check failed");
// Clocked check that also holds during reset.
`define CHBD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("chbd check failed");
`else
`define CHBD_ASSERT(lbl, prop)
`define CHBD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ src/chbd_pkg.sv @@
// Types and constants shared by the complex halfband decimator modules.
`default_nettype none
package chbd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int TAP_W       = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int EVEN_REG_N  = 4;
  localparam int EVEN_IDX_W  = 4;   // selects one of the 16 even coefficients
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = PROD_W + 5;  // up to 17 products summed exactly
  localparam int Q_SHIFT     = 15;
  localparam int TAP_MIN     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_0_3    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_4_7    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_8_11   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_12_15  = 3'd5;

  localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 5'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [EVEN_REG_N-1:0][CFG_W-1:0] coef_bank_t;

  localparam coef_t CENTER_COEF_RESET = 16'sd16384;

  // Control that travels with one multiply-accumulate step.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } step_ctrl_t;

endpackage
`default_nettype wire

@@ src/chbd_lane.sv @@
// One filter lane: sample delay line, tap multiplier and accumulator.
`default_nettype none
module chbd_lane #(
  parameter int MAX_TAPS = 31,
  localparam int AW = $clog2(MAX_TAPS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                shift_en,
  input  wire chbd_pkg::sample_t   sample_in,
  input  wire chbd_pkg::step_ctrl_t step,
  input  wire logic [AW-1:0]       step_addr,
  input  wire chbd_pkg::coef_t     step_coef,
  input  wire logic                take,
  output chbd_pkg::acc_t           acc,
  output logic                     done
);
  import chbd_pkg::*;

  sample_t hist [MAX_TAPS];
  sample_t tap_sample;
  logic signed [PROD_W-1:0] prod;
  step_ctrl_t prod_ctrl;

  // Delay line, newest sample at index 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) hist[k] <= '0;
    end else if (shift_en) begin
      for (int k = MAX_TAPS - 1; k > 0; k--) hist[k] <= hist[k-1];
      hist[0] <= sample_in;
    end
  end

  assign tap_sample = hist[step_addr];

  always_ff @(posedge clk) begin
    prod <= tap_sample * step_coef;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctrl <= '0;
      done      <= 1'b0;
    end else begin
      prod_ctrl <= step;
      if (prod_ctrl.valid && prod_ctrl.last) done <= 1'b1;
      else if (take) done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ctrl.valid) begin
      if (prod_ctrl.first) acc <= ACC_W'(prod);
      else acc <= acc + ACC_W'(prod);
    end
  end

endmodule
`default_nettype wire

@@ src/chbd_seq.sv @@
// Tap sequencer: walks the center tap and the even taps, one per cycle.
`default_nettype none
module chbd_seq #(
  parameter int MAX_TAPS = 31,
  localparam int AW = $clog2(MAX_TAPS),
  localparam int CW = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    take,
  input  wire logic [chbd_pkg::TAP_W-1:0] tap_count,
  input  wire chbd_pkg::coef_t         center_coefficient,
  input  wire chbd_pkg::coef_bank_t    even_coefficients,
  output logic                         busy,
  output chbd_pkg::step_ctrl_t         step,
  output logic [AW-1:0]                step_addr,
  output chbd_pkg::coef_t              step_coef
);
  import chbd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CENTER = 2'd1;
  localparam logic [1:0] ST_EVEN   = 2'd2;
  localparam logic [1:0] ST_WAIT   = 2'd3;

  logic [1:0] state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [EVEN_IDX_W-1:0] m, m_next;
  logic [CW-1:0] n_eff;
  logic [AW-1:0] n_m1, center_addr;
  coef_t even_sel;
  logic last_even;

  // Clamp the tap count into the supported range.
  always_comb begin
    if (tap_count < TAP_W'(TAP_MIN)) n_eff = CW'(TAP_MIN);
    else if (32'(tap_count) > MAX_TAPS) n_eff = CW'(MAX_TAPS);
    else n_eff = CW'(tap_count);
  end

  assign n_m1        = AW'(n_eff - CW'(1));
  assign center_addr = n_m1 - (n_m1 >> 1);
  assign even_sel    = even_coefficients[m[EVEN_IDX_W-1:2]][{m[1:0], 4'b0000} +: COEF_W];
  assign last_even   = idx < AW'(2);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    m_next     = m;
    step       = '0;
    step_addr  = idx;
    step_coef  = even_sel;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CENTER;
          idx_next   = n_m1;
          m_next     = '0;
        end
      end
      ST_CENTER: begin
        step.valid = 1'b1;
        step.first = 1'b1;
        step_addr  = center_addr;
        step_coef  = center_coefficient;
        state_next = ST_EVEN;
      end
      ST_EVEN: begin
        step.valid = 1'b1;
        step.last  = last_even;
        if (last_even) begin
          state_next = ST_WAIT;
        end else begin
          idx_next = idx - AW'(2);
          m_next   = m + EVEN_IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    m   <= m_next;
  end

  assign busy = state != ST_IDLE;

endmodule
`default_nettype wire

@@ src/chbd_merge.sv @@
// Output stage: scales the I and Q lane sums and holds the result transaction.
`default_nettype none
module chbd_merge (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire chbd_pkg::acc_t acc_i,
  input  wire chbd_pkg::acc_t acc_q,
  input  wire logic           done,
  input  wire logic           out_ready,
  output logic                out_valid,
  output chbd_pkg::sample_t   filtered_inphase,
  output chbd_pkg::sample_t   filtered_quadrature,
  output logic                take
);
  import chbd_pkg::*;

  // Load when the slot is empty or being emptied this cycle.
  assign take = done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (take) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  // Shift right by the Q15 scale and keep the low sample bits.
  always_ff @(posedge clk) begin
    if (take) begin
      filtered_inphase    <= acc_i[Q_SHIFT +: SAMPLE_W];
      filtered_quadrature <= acc_q[Q_SHIFT +: SAMPLE_W];
    end
  end

endmodule
`default_nettype wire

@@ src/complex_halfband_decimator_top.sv @@
// Top level of the complex halfband decimate-by-2 FIR.
// Odd input samples only enter the delay line.
// Each even sample starts a pass over the center tap and the even taps of the clamped
// tap count; input is held off until the pass result is loaded into the output register.
// Synchronous reset clears the delay line, decimation phase and registers to defaults.
`default_nettype none
`include "complex_halfband_decimator_top_defines.svh"
module complex_halfband_decimator_top #(
  parameter int MAX_TAPS = 31
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration write port
  input  wire logic                       cfg_write,
  input  wire logic [chbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [chbd_pkg::CFG_W-1:0] cfg_data,
  // input sample channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire chbd_pkg::sample_t          sample_inphase,
  input  wire chbd_pkg::sample_t          sample_quadrature,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output chbd_pkg::sample_t               filtered_inphase,
  output chbd_pkg::sample_t               filtered_quadrature
);
  import chbd_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);

  logic [TAP_W-1:0] tap_count;
  coef_t            center_coefficient;
  coef_bank_t       even_coefficients;
  logic             phase;
  logic             in_fire, start, busy, take;
  step_ctrl_t       step;
  logic [AW-1:0]    step_addr;
  coef_t            step_coef;
  acc_t             acc_i, acc_q;
  logic             done_i, done_q;

  // Configuration registers; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count          <= TAP_COUNT_RESET;
      center_coefficient <= CENTER_COEF_RESET;
      even_coefficients  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TAP_COUNT:   tap_count <= cfg_data[TAP_W-1:0];
        REG_CENTER_COEF: center_coefficient <= cfg_data[COEF_W-1:0];
        REG_EVEN_0_3:    even_coefficients[0] <= cfg_data;
        REG_EVEN_4_7:    even_coefficients[1] <= cfg_data;
        REG_EVEN_8_11:   even_coefficients[2] <= cfg_data;
        REG_EVEN_12_15:  even_coefficients[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off input while a filter pass is running or its result is pending.
  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  // Every second transaction launches a filter pass.
  assign start    = in_fire && phase;

  always_ff @(posedge clk) begin
    if (rst) phase <= 1'b0;
    else if (in_fire) phase <= !phase;
  end

  chbd_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .take               (take),
    .tap_count          (tap_count),
    .center_coefficient (center_coefficient),
    .even_coefficients  (even_coefficients),
    .busy               (busy),
    .step               (step),
    .step_addr          (step_addr),
    .step_coef          (step_coef)
  );

  // I and Q lanes run in lockstep on the same tap sequence.
  chbd_lane #(.MAX_TAPS(MAX_TAPS)) u_lane_i (
    .clk       (clk),
    .rst       (rst),
    .shift_en  (in_fire),
    .sample_in (sample_inphase),
    .step      (step),
    .step_addr (step_addr),
    .step_coef (step_coef),
    .take      (take),
    .acc       (acc_i),
    .done      (done_i)
  );

  chbd_lane #(.MAX_TAPS(MAX_TAPS)) u_lane_q (
    .clk       (clk),
    .rst       (rst),
    .shift_en  (in_fire),
    .sample_in (sample_quadrature),
    .step      (step),
    .step_addr (step_addr),
    .step_coef (step_coef),
    .take      (take),
    .acc       (acc_q),
    .done      (done_q)
  );

  chbd_merge u_merge (
    .clk                 (clk),
    .rst                 (rst),
    .acc_i               (acc_i),
    .acc_q               (acc_q),
    .done                (done_i),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .filtered_inphase    (filtered_inphase),
    .filtered_quadrature (filtered_quadrature),
    .take                (take)
  );

  // Lanes finish together.
  `CHBD_ASSERT(a_lanes_lockstep, done_i == done_q)
  // A pending lane result blocks new input.
  `CHBD_ASSERT(a_done_blocks_input, done_i |-> !in_ready)
  // A launching transaction puts the sequencer to work.
  `CHBD_ASSERT(a_start_busy, start |=> busy)
  // A loaded result shows up on the output.
  `CHBD_ASSERT(a_take_valid, take |=> out_valid)

endmodule
`default_nettype wire

@@ tb/sv/tb_complex_halfband_decimator_top.sv @@
// Self-checking testbench for the complex halfband decimate-by-2 FIR top level.
module tb_complex_halfband_decimator_top;
  import chbd_pkg::*;

  localparam int MAX_TAPS     = 31;
  // Wide margin for the longest pass (31 taps) to finish after the transaction.
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 280;
  localparam int RECONFIG_GAP = 70;

  // Indexes the block does not decode; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] EVEN_REGS [EVEN_REG_N] =
    '{REG_EVEN_0_3, REG_EVEN_4_7, REG_EVEN_8_11, REG_EVEN_12_15};

  typedef struct packed {
    sample_t fi;
    sample_t fq;
  } filtered_t;

  // Every block input starts at a known value.
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  sample_t              sample_inphase    = '0;
  sample_t              sample_quadrature = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sample_t              filtered_inphase;
  sample_t              filtered_quadrature;

  // Receiver hold-off request, raised by the back-pressure test.
  logic out_hold = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int config_count  = 0;

  always #4 clk = ~clk;

  complex_halfband_decimator_top #(
    .MAX_TAPS(MAX_TAPS)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .sample_inphase     (sample_inphase),
    .sample_quadrature  (sample_quadrature),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .filtered_inphase   (filtered_inphase),
    .filtered_quadrature(filtered_quadrature)
  );

  // ---------------------------------------------------------------------------
  // Filter predictor: its own copy of the registers, delay line and phase.
  // ---------------------------------------------------------------------------
  logic [TAP_W-1:0] taps_set;
  coef_t            center_set;
  logic [CFG_W-1:0] even_bank [EVEN_REG_N];
  sample_t          line_i [MAX_TAPS];   // newest sample at index 0
  sample_t          line_q [MAX_TAPS];
  logic             odd_seen;            // high when the next sample completes a pair
  filtered_t        filtered_due [$];    // predicted outputs, oldest first

  function automatic void model_clear();
    taps_set   = TAP_COUNT_RESET;
    center_set = CENTER_COEF_RESET;
    odd_seen   = 1'b0;
    for (int r = 0; r < EVEN_REG_N; r++) even_bank[r] = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      line_i[k] = '0;
      line_q[k] = '0;
    end
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_TAP_COUNT:   taps_set     = data[TAP_W-1:0];
      REG_CENTER_COEF: center_set   = data[COEF_W-1:0];
      REG_EVEN_0_3:    even_bank[0] = data;
      REG_EVEN_4_7:    even_bank[1] = data;
      REG_EVEN_8_11:   even_bank[2] = data;
      REG_EVEN_12_15:  even_bank[3] = data;
      default: ;
    endcase
  endfunction

  // Shift one sample into the line; on the second of a pair, predict the output.
  function automatic void filter_and_decimate(sample_t si, sample_t sq);
    int unsigned        n;
    int unsigned        mid;
    logic signed [63:0] acc_i;
    logic signed [63:0] acc_q;
    coef_t              c;
    filtered_t          res;
    for (int k = MAX_TAPS - 1; k > 0; k--) begin
      line_i[k] = line_i[k-1];
      line_q[k] = line_q[k-1];
    end
    line_i[0] = si;
    line_q[0] = sq;
    if (!odd_seen) begin
      odd_seen = 1'b1;
      return;
    end
    odd_seen = 1'b0;
    // Clamp the tap count into the supported range.
    n = (taps_set < TAP_MIN) ? TAP_MIN : taps_set;
    if (n > MAX_TAPS) n = MAX_TAPS;
    // Window position p sits at line index n-1-p; tap 0 is the oldest.
    mid   = (n - 1) / 2;
    acc_i = longint'(center_set) * longint'(line_i[n-1-mid]);
    acc_q = longint'(center_set) * longint'(line_q[n-1-mid]);
    for (int j = 0; j < n; j += 2) begin
      // Even tap j uses coefficient j/2: register j/8, lane (j/2)%4.
      c     = even_bank[j/8][16*((j/2)%4) +: 16];
      acc_i = acc_i + longint'(c) * longint'(line_i[n-1-j]);
      acc_q = acc_q + longint'(c) * longint'(line_q[n-1-j]);
    end
    // Shift right by the Q15 point and keep the low 16 bits (wraps).
    res.fi = acc_i[Q_SHIFT +: SAMPLE_W];
    res.fq = acc_q[Q_SHIFT +: SAMPLE_W];
    filtered_due.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Q15 value biased toward the extremes and zero.
  function automatic logic [15:0] rand_q15();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Tap count: mostly well-formed 4k+3, plus clamped, even and extreme counts.
  function automatic logic [TAP_W-1:0] rand_taps();
    case ($urandom_range(3))
      0, 1:    return TAP_W'(4 * $urandom_range(0, 7) + 3);
      2:       return TAP_W'($urandom_range(0, 31));
      default: return ($urandom_range(1) == 0) ? TAP_W'(0) : TAP_W'(31);
    endcase
  endfunction

  // Drive one register write; the write takes effect at the next edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    model_write(idx, data);
    config_count++;
  endtask

  // Write every register back to back, starting with a spare index that must be
  // ignored. Unused upper data bits carry noise. Call only while the block is idle.
  task automatic set_config(logic [TAP_W-1:0] taps, logic [15:0] center,
                            logic [CFG_W-1:0] b0, logic [CFG_W-1:0] b1,
                            logic [CFG_W-1:0] b2, logic [CFG_W-1:0] b3);
    write_reg(($urandom_range(1) == 0) ? REG_SPARE_6 : REG_SPARE_7, {$urandom(), $urandom()});
    write_reg(REG_TAP_COUNT, {$urandom(), 27'($urandom()), taps});
    write_reg(REG_CENTER_COEF, {$urandom(), 16'($urandom()), center});
    write_reg(EVEN_REGS[0], b0);
    write_reg(EVEN_REGS[1], b1);
    write_reg(EVEN_REGS[2], b2);
    write_reg(EVEN_REGS[3], b3);
    cfg_write <= 1'b0;
  endtask

  task automatic random_config();
    set_config(rand_taps(), rand_q15(),
               {rand_q15(), rand_q15(), rand_q15(), rand_q15()},
               {rand_q15(), rand_q15(), rand_q15(), rand_q15()},
               {rand_q15(), rand_q15(), rand_q15(), rand_q15()},
               {rand_q15(), rand_q15(), rand_q15(), rand_q15()});
  endtask

  // Offer one sample and hold it until the transaction completes.
  task automatic send_sample(sample_t si, sample_t sq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    sample_inphase    <= si;
    sample_quadrature <= sq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_and_decimate(si, sq);
    sent_count++;
  endtask

  // Drop valid, wait for every predicted output, then let an odd sample finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker: random ready, compare each output transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_outputs
    filtered_t want;
    out_ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
    if (!rst && out_valid && out_ready) begin
      if (filtered_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: I=%0d Q=%0d", filtered_inphase, filtered_quadrature);
      end else begin
        want = filtered_due.pop_front();
        checked_count++;
        if (filtered_inphase !== want.fi || filtered_quadrature !== want.fq) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output %0d mismatch: I exp %0d got %0d, Q exp %0d got %0d",
                     checked_count, want.fi, filtered_inphase, want.fq, filtered_quadrature);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: three taps, center 0.5, no even taps; the line starts at zero.
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh0001, 16'shFFFF);
    send_sample(16'sh0000, 16'sh0000);
  endtask

  // Full-scale coefficients against full-scale samples force the output to wrap.
  task automatic test_coefficient_extremes();
    settle();
    set_config(TAP_W'(7), 16'h8000, 64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_7FFF_8000,
               64'h0, 64'h0);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
  endtask

  // Tap count below the minimum, one whose center index is even, and the maximum.
  task automatic test_tap_count_edges();
    settle();
    set_config(TAP_W'(1), 16'h7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h0, 64'h0, 64'h0);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh1234, 16'shEDCB);
    settle();
    // Five taps: the center sample also picks up its even coefficient.
    set_config(TAP_W'(5), 16'h4000, 64'h0000_1000_E000_2000, 64'h0, 64'h0, 64'h0);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh4000, 16'shC000);
    settle();
    set_config(TAP_W'(31), 16'h8000, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
               64'h8000_7FFF_8000_7FFF, 64'hFFFF_0001_FFFF_0001);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh7FFF);
  endtask

  // Random samples with a fresh random setting every RECONFIG_GAP items.
  task automatic test_random_traffic(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % RECONFIG_GAP == 0) begin
        settle();
        random_config();
      end
      send_sample(rand_q15(), rand_q15());
    end
  endtask

  // Hold off the receiver for a long stretch while samples keep coming, so the
  // block fills up and stalls its input.
  task automatic test_backpressure();
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(TAP_W'(31), rand_q15(),
               {rand_q15(), rand_q15(), rand_q15(), rand_q15()},
               {rand_q15(), rand_q15(), rand_q15(), rand_q15()},
               {rand_q15(), rand_q15(), rand_q15(), rand_q15()},
               {rand_q15(), rand_q15(), rand_q15(), rand_q15()});
    fork
      begin
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++) send_sample(rand_q15(), rand_q15());
  endtask

  initial begin : run_tests
    int guard;
    model_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sender idles a third of the time, receiver most of the time.
    send_idle_pct = 33;
    recv_idle_pct = 85;
    test_reset_defaults();
    test_coefficient_extremes();
    test_tap_count_edges();

    test_random_traffic(33, 85);
    test_random_traffic(85, 33);
    test_random_traffic(0, 0);
    test_backpressure();

    // Wait out every predicted output, bounded, then the tail of any odd sample.
    in_valid <= 1'b0;
    guard = 0;
    while (filtered_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (filtered_due.size() != 0) begin
      $display("%0d predicted outputs never arrived", filtered_due.size());
      mismatches += filtered_due.size();
    end

    $display("sent %0d samples, checked %0d outputs, %0d register writes over tap counts 0..31",
             sent_count, checked_count, config_count);
    $display("idling on both sides, a %0d-cycle receiver hold-off, %0d failures",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("tb_complex_halfband_decimator_top OK");
    end else begin
      $display("tb_complex_halfband_decimator_top NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("timeout waiting for the block");
    $display("tb_complex_halfband_decimator_top NOT OK");
    $finish;
  end

endmodule
